@@ rtl/core/ptrc_pkg.sv @@
// Package for the planar tile to raster converter.
// Holds the picture geometry, counter widths and the shade lookup.
// No dependencies.
package ptrc_pkg;

  // Picture size in 8x8 tiles.
  localparam int TILE_COLUMNS = 16;
  localparam int TILE_ROWS    = 14;

  localparam int COL_W = (TILE_COLUMNS > 1) ? $clog2(TILE_COLUMNS) : 1;
  localparam int ROW_W = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
  localparam int RIT_W = 3;

  localparam int PLANE_W  = 8;
  localparam int SHADE_W  = 8;
  localparam int PIXELS   = 8;
  localparam int X_W      = 8;
  localparam int Y_W      = 7;
  localparam int IN_DATA_W  = 2 * PLANE_W;
  localparam int OUT_FIELD_W = X_W + Y_W + PIXELS * SHADE_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(TILE_COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(TILE_ROWS - 1);
  localparam logic [RIT_W-1:0] RIT_LAST = '1;

  localparam logic [X_W-1:0] BORDER_X = X_W'(16);
  localparam logic [Y_W-1:0] BORDER_Y = Y_W'(16);

  typedef logic [PIXELS-1:0][SHADE_W-1:0] shade_row_t;

  typedef struct packed {
    shade_row_t shades;
    logic       both_nonzero;
  } decode_res_t;

  // Pixel index: bit 0 from the first plane, bit 1 from the second plane.
  function automatic logic [SHADE_W-1:0] shade_of_index(input logic [1:0] idx);
    logic [SHADE_W-1:0] s;
    case (idx)
      2'd0:    s = 8'd255;
      2'd1:    s = 8'd170;
      2'd2:    s = 8'd85;
      default: s = 8'd0;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/core/ptrc_decode.sv @@
// Bitplane decoder: turns one pair of plane bytes into eight gray shades.
// Depends on ptrc_pkg.
module ptrc_decode
  import ptrc_pkg::*;
(
  input  logic [PLANE_W-1:0] first_plane,
  input  logic [PLANE_W-1:0] second_plane,
  output decode_res_t        res
);

  always_comb begin
    for (int p = 0; p < PIXELS; p++) begin
      // Pixel 0 is the leftmost, taken from the most significant bits.
      res.shades[p] = shade_of_index({second_plane[PIXELS-1-p], first_plane[PIXELS-1-p]});
    end
    res.both_nonzero = (first_plane != '0) && (second_plane != '0);
  end

endmodule

@@ rtl/core/planar_tile_to_raster_converter.sv @@
// Top level of the planar tile to raster converter.
// Depends on ptrc_pkg and ptrc_decode.
//
// One transaction per cycle in each direction while out_tready is high: each input
// transaction carries one tile row as two bitplane bytes and gives exactly one
// output transaction with its raster position and eight gray shades. Data passes
// through an input register followed by the result register, so the input can take
// one more transaction while a result is held by backpressure. Tile rows run top to
// bottom within a tile, tiles left to right, then tile rows downward; tlast marks
// the final row of the picture and tuser then tells whether the picture was blank.
// Counters restart on their own after the last row. border_enable may change only
// while the block is idle.
module planar_tile_to_raster_converter
  import ptrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,   // border_enable
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [7:0] first_plane_byte, [15:8] second_plane_byte
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] pixel_x_base, [14:8] pixel_y, [22:15] shade_0 ... [78:71] shade_7, [79] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,     // picture_done
  output logic                  out_tuser      // picture_blank
);

  logic                 border_en_r;
  logic                 in_valid_r;
  logic [PLANE_W-1:0]   first_r;
  logic [PLANE_W-1:0]   second_r;
  logic [COL_W-1:0]     col_cnt_r;
  logic [ROW_W-1:0]     row_cnt_r;
  logic [RIT_W-1:0]     rit_cnt_r;
  logic                 blank_so_far_r;
  logic                 out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                 out_last_r;
  logic                 out_user_r;

  decode_res_t          dec;
  logic                 out_free;
  logic                 advance;
  logic                 last_rit;
  logic                 last_col;
  logic                 last_row;
  logic                 done_c;
  logic                 blank_c;
  logic [X_W-1:0]       x_c;
  logic [Y_W-1:0]       y_c;
  logic [OUT_DATA_W-1:0] data_nxt;

  ptrc_decode u_decode (
    .first_plane  (first_r),
    .second_plane (second_r),
    .res          (dec)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  assign last_rit = (rit_cnt_r == RIT_LAST);
  assign last_col = (col_cnt_r == COL_LAST);
  assign last_row = (row_cnt_r == ROW_LAST);
  assign done_c   = last_rit && last_col && last_row;
  assign blank_c  = blank_so_far_r && !dec.both_nonzero;

  // 8 * column and 8 * tile row + row in tile are plain concatenations.
  assign x_c = X_W'({col_cnt_r, 3'b000}) + (border_en_r ? BORDER_X : '0);
  assign y_c = Y_W'({row_cnt_r, rit_cnt_r}) + (border_en_r ? BORDER_Y : '0);

  always_comb begin
    data_nxt = '0;
    data_nxt[X_W-1:0] = x_c;
    data_nxt[X_W +: Y_W] = y_c;
    for (int p = 0; p < PIXELS; p++) begin
      data_nxt[X_W + Y_W + p*SHADE_W +: SHADE_W] = dec.shades[p];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      border_en_r    <= 1'b0;
      in_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      col_cnt_r      <= '0;
      row_cnt_r      <= '0;
      rit_cnt_r      <= '0;
      blank_so_far_r <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        border_en_r <= cfg_wr_data;
      end
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
      if (advance) begin
        if (done_c) begin
          col_cnt_r      <= '0;
          row_cnt_r      <= '0;
          rit_cnt_r      <= '0;
          blank_so_far_r <= 1'b1;
        end else begin
          blank_so_far_r <= blank_c;
          if (!last_rit) begin
            rit_cnt_r <= rit_cnt_r + 1'b1;
          end else begin
            rit_cnt_r <= '0;
            if (!last_col) begin
              col_cnt_r <= col_cnt_r + 1'b1;
            end else begin
              col_cnt_r <= '0;
              row_cnt_r <= row_cnt_r + 1'b1;
            end
          end
        end
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      first_r  <= in_tdata[PLANE_W-1:0];
      second_r <= in_tdata[PLANE_W +: PLANE_W];
    end
    if (advance) begin
      out_data_r <= data_nxt;
      out_last_r <= done_c;
      out_user_r <= done_c && blank_c;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  a_blank_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_user_r |-> out_last_r)
    else $error("picture_blank set on a row that is not the last");

  a_counters_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (col_cnt_r <= COL_LAST) && (row_cnt_r <= ROW_LAST))
    else $error("tile counter beyond picture size");

  a_restart_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    advance && done_c |=> (col_cnt_r == '0) && (row_cnt_r == '0) && (rit_cnt_r == '0)
      && blank_so_far_r)
    else $error("counters did not restart after the last row");

  a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result lost after an item left the input register");

endmodule
